@@ rtl/tdsm_pkg.sv @@
// package: widths, codes, state and command types for the tds meter
`timescale 1ns / 1ps
package tdsm_pkg;

  localparam int SAMPLE_COUNT_DEF = 32;

  localparam int ADC_W  = 12;
  localparam int TEMP_W = 12;
  localparam int PPM_W  = 16;
  localparam int NUM_W  = 41;
  localparam int DEN_W  = 22;
  localparam int BIT_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_MV          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE       = 2'd3;

  localparam logic [15:0] SAMPLE_INTERVAL_RST  = 16'd40;
  localparam logic [31:0] PUBLISH_INTERVAL_RST = 32'd1000;
  localparam logic [12:0] VREF_MV_RST          = 13'd3300;
  localparam logic [11:0] FULL_SCALE_RST       = 12'd4095;

  localparam logic signed [TEMP_W-1:0] TEMP_DEFAULT = 12'sd480;
  localparam logic [17:0] V_MAX       = 18'h3FFFF;
  localparam logic [19:0] CV_MAX      = 20'd524288;
  localparam logic [25:0] PPM_SAT_LIM = 26'd1638400;
  localparam logic [21:0] PPM_RECIP   = 22'd2684355;
  localparam logic [15:0] PPM_MAX     = 16'hFFFF;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL_INIT, ST_SEL_RUN, ST_VOLT_MUL, ST_VOLT_DIV, ST_VOLT_WAIT,
    ST_COMP_MUL, ST_COMP_DIV, ST_COMP_WAIT, ST_SQUARE, ST_CUBE, ST_TERMS,
    ST_POLY, ST_FINISH, ST_PUBLISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_TICK, OP_SEL_INIT, OP_SEL_RUN, OP_VOLT_MUL, OP_DIV_START,
    OP_COMP_MUL, OP_SQUARE, OP_CUBE, OP_TERMS, OP_POLY, OP_FINISH, OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic publish;
    logic sel_done;
    logic div_busy;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/tdsm_if.sv @@
// valid/ready channel interfaces for tick items and readings
`timescale 1ns / 1ps
interface tdsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [tdsm_pkg::ADC_W-1:0]          adc_sample;
  logic signed [tdsm_pkg::TEMP_W-1:0]  temperature;
  logic                                temperature_valid;

  modport source (output valid, adc_sample, temperature, temperature_valid, input ready);
  modport sink   (input valid, adc_sample, temperature, temperature_valid, output ready);
endinterface

interface tdsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdsm_pkg::PPM_W-1:0]  tds_ppm;
  logic                        saturated;

  modport source (output valid, tds_ppm, saturated, input ready);
  modport sink   (input valid, tds_ppm, saturated, output ready);
endinterface

@@ rtl/tdsm_ram.sv @@
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module tdsm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/tdsm_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tdsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tdsm_pkg::NUM_W-1:0] num,
  input  logic [tdsm_pkg::DEN_W-1:0] den,
  output logic                       busy,
  output logic [tdsm_pkg::NUM_W-1:0] quot
);
  import tdsm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
endmodule

@@ rtl/tdsm_ctrl.sv @@
// sequencer for tick handling, median sweep and the conversion steps
`timescale 1ns / 1ps
module tdsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdsm_pkg::status_t status,
  output tdsm_pkg::cmd_t    cmd
);
  import tdsm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid && status.publish) state_nxt = ST_SEL_INIT;
      ST_SEL_INIT:  state_nxt = ST_SEL_RUN;
      ST_SEL_RUN:   if (status.sel_done) state_nxt = ST_VOLT_MUL;
      ST_VOLT_MUL:  state_nxt = ST_VOLT_DIV;
      ST_VOLT_DIV:  state_nxt = ST_VOLT_WAIT;
      ST_VOLT_WAIT: if (!status.div_busy) state_nxt = ST_COMP_MUL;
      ST_COMP_MUL:  state_nxt = ST_COMP_DIV;
      ST_COMP_DIV:  state_nxt = ST_COMP_WAIT;
      ST_COMP_WAIT: if (!status.div_busy) state_nxt = ST_SQUARE;
      ST_SQUARE:    state_nxt = ST_CUBE;
      ST_CUBE:      state_nxt = ST_TERMS;
      ST_TERMS:     state_nxt = ST_POLY;
      ST_POLY:      state_nxt = ST_FINISH;
      ST_FINISH:    state_nxt = ST_PUBLISH;
      ST_PUBLISH:   if (!status.out_busy) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_TICK;
      end
      ST_SEL_INIT: cmd.op = OP_SEL_INIT;
      ST_SEL_RUN:  cmd.op = OP_SEL_RUN;
      ST_VOLT_MUL: cmd.op = OP_VOLT_MUL;
      ST_VOLT_DIV, ST_COMP_DIV: cmd.op = OP_DIV_START;
      ST_COMP_MUL: cmd.op = OP_COMP_MUL;
      ST_SQUARE:   cmd.op = OP_SQUARE;
      ST_CUBE:     cmd.op = OP_CUBE;
      ST_TERMS:    cmd.op = OP_TERMS;
      ST_POLY:     cmd.op = OP_POLY;
      ST_FINISH:   cmd.op = OP_FINISH;
      ST_PUBLISH:  if (!status.out_busy) cmd.op = OP_OUT_LOAD;
      default:     cmd.op = OP_NONE;
    endcase
  end
endmodule

@@ rtl/tdsm_datapath.sv @@
// datapath: registers, tick counters, sample ring, median select, conversion math
`timescale 1ns / 1ps
module tdsm_datapath #(
  parameter int SAMPLE_COUNT = tdsm_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tdsm_pkg::cmd_t                       cmd,
  output tdsm_pkg::status_t                    status,
  input  logic [tdsm_pkg::ADC_W-1:0]           in_adc_sample,
  input  logic signed [tdsm_pkg::TEMP_W-1:0]   in_temperature,
  input  logic                                 in_temperature_valid,
  input  logic                                 cfg_we,
  input  logic [tdsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdsm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [tdsm_pkg::PPM_W-1:0]           out_tds_ppm,
  output logic                                 out_saturated
);
  import tdsm_pkg::*;

  localparam int SLOT_W = $clog2(SAMPLE_COUNT);
  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam logic [CNT_W-1:0]  K_LO      = CNT_W'((SAMPLE_COUNT - 1) / 2);
  localparam logic [CNT_W-1:0]  K_HI      = CNT_W'(SAMPLE_COUNT / 2);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLE_COUNT - 1);

  // configuration
  logic [15:0] sample_int_r;
  logic [31:0] publish_int_r;
  logic [12:0] vref_r;
  logic [11:0] fs_r;

  // tick state
  logic [15:0]       ts_r;
  logic [31:0]       tp_r;
  logic [SLOT_W-1:0] slot_r;
  logic              vld_r [SAMPLE_COUNT];
  logic [15:0]       ts_inc;
  logic [31:0]       tp_inc;
  logic              sample_due;
  logic              publish;

  // median select
  logic [CNT_W-1:0]  iss_r;
  logic              rv_r;
  logic [SLOT_W-1:0] ridx_r;
  logic [BIT_W-1:0]  bit_r;
  logic [ADC_W-1:0]  pre_lo_r, pre_hi_r;
  logic [CNT_W-1:0]  k_lo_r, k_hi_r, cnt_lo_r, cnt_hi_r;
  logic [ADC_W-1:0]  rdata, x;
  logic [ADC_W:0]    mask_ext;
  logic [ADC_W-1:0]  mask;
  logic              m_lo, m_hi, last_elem, ram_re;
  logic [CNT_W-1:0]  cnt_lo_n, cnt_hi_n;
  logic [ADC_W:0]    med_sum;
  logic [ADC_W-1:0]  med;

  // conversion
  logic signed [TEMP_W-1:0] t_eff_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [19:0]      cv_r;
  logic [22:0]      v2_r;
  logic [25:0]      v3_r;
  logic [39:0]      a_r;
  logic [37:0]      b_r;
  logic [36:0]      c_r;
  logic             sat_r;
  logic [PPM_W-1:0] res_ppm_r;
  logic             res_sat_r;
  logic [NUM_W-1:0] quot;
  logic             div_busy;
  logic             div_start;
  logic [11:0]      fs_eff;
  logic [17:0]      v_clamp;
  logic             v_over;
  logic [19:0]      cv_clamp;
  logic             cv_over;
  logic signed [TEMP_W:0] den_s;
  logic [11:0]      den_t;
  logic [39:0]      sq_full;
  logic [48:0]      cube_full;
  logic [40:0]      pos;
  logic [25:0]      poly_n;
  logic [42:0]      poly_prod;

  // output register
  logic             out_valid_r;
  logic [PPM_W-1:0] out_ppm_r;
  logic             out_sat_r;

  assign ts_inc     = (ts_r == 16'hFFFF) ? ts_r : ts_r + 16'd1;
  assign tp_inc     = (tp_r == 32'hFFFF_FFFF) ? tp_r : tp_r + 32'd1;
  assign sample_due = ts_inc >= sample_int_r;
  assign publish    = tp_inc >= publish_int_r;

  assign ram_re = (cmd.op == OP_SEL_RUN) && (iss_r < CNT_W'(SAMPLE_COUNT));

  tdsm_ram #(.WIDTH(ADC_W), .DEPTH(SAMPLE_COUNT)) u_ring (
    .clk   (clk),
    .we    ((cmd.op == OP_TICK) && sample_due),
    .waddr (slot_r),
    .wdata (in_adc_sample),
    .re    (ram_re),
    .raddr (iss_r[SLOT_W-1:0]),
    .rdata (rdata)
  );

  assign div_start = cmd.op == OP_DIV_START;

  tdsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  // radix select of the two middle ranks, one bit per ring sweep
  assign x         = vld_r[ridx_r] ? rdata : '0;
  assign mask_ext  = {(ADC_W + 1){1'b1}} << (5'(bit_r) + 5'd1);
  assign mask      = mask_ext[ADC_W-1:0];
  assign m_lo      = (((x ^ pre_lo_r) & mask) == '0) && !x[bit_r];
  assign m_hi      = (((x ^ pre_hi_r) & mask) == '0) && !x[bit_r];
  assign cnt_lo_n  = cnt_lo_r + CNT_W'(m_lo);
  assign cnt_hi_n  = cnt_hi_r + CNT_W'(m_hi);
  assign last_elem = rv_r && (ridx_r == LAST_SLOT);
  assign med_sum   = {1'b0, pre_lo_r} + {1'b0, pre_hi_r};
  assign med       = med_sum[ADC_W:1];

  assign fs_eff   = (fs_r == '0) ? 12'd1 : fs_r;
  assign v_over   = quot > NUM_W'(V_MAX);
  assign v_clamp  = v_over ? V_MAX : quot[17:0];
  assign cv_over  = quot > NUM_W'(CV_MAX);
  assign cv_clamp = cv_over ? CV_MAX : quot[19:0];
  assign den_s    = (TEMP_W + 1)'(13'sd400) + (TEMP_W + 1)'(t_eff_r);
  assign den_t    = (den_s < 13'sd1) ? 12'd1 : den_s[11:0];
  assign sq_full  = 40'(cv_clamp) * 40'(cv_clamp);
  assign cube_full = 49'(v2_r) * 49'(cv_r);
  assign pos      = 41'(a_r) + 41'(c_r);

  // ppm scale: drop 2^15, then divide by 25 with a reciprocal multiply
  assign poly_n    = num_r[NUM_W-1:15];
  assign poly_prod = 43'(poly_n[20:0]) * 43'(PPM_RECIP);

  assign status.publish  = publish;
  assign status.sel_done = (cmd.op == OP_SEL_RUN) && last_elem && (bit_r == '0);
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid_r && !out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_int_r  <= SAMPLE_INTERVAL_RST;
      publish_int_r <= PUBLISH_INTERVAL_RST;
      vref_r        <= VREF_MV_RST;
      fs_r          <= FULL_SCALE_RST;
      ts_r          <= '0;
      tp_r          <= '0;
      slot_r        <= '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) vld_r[i] <= 1'b0;
      iss_r         <= '0;
      rv_r          <= 1'b0;
      bit_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_INTERVAL:  sample_int_r  <= cfg_wdata[15:0];
          REG_PUBLISH_INTERVAL: publish_int_r <= cfg_wdata[31:0];
          REG_VREF_MV:          vref_r        <= cfg_wdata[12:0];
          REG_FULL_SCALE:       fs_r          <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_TICK) begin
        ts_r <= sample_due ? '0 : ts_inc;
        tp_r <= publish ? '0 : tp_inc;
        if (sample_due) begin
          vld_r[slot_r] <= 1'b1;
          slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
        end
      end
      if (cmd.op == OP_SEL_INIT) begin
        iss_r <= '0;
        rv_r  <= 1'b0;
        bit_r <= BIT_W'(ADC_W - 1);
      end else if (cmd.op == OP_SEL_RUN) begin
        rv_r <= ram_re;
        if (ram_re) begin
          iss_r <= iss_r + CNT_W'(1);
        end else if (last_elem) begin
          iss_r <= '0;
          bit_r <= bit_r - BIT_W'(1);
        end
      end
      if (cmd.op == OP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TICK) begin
      t_eff_r <= in_temperature_valid ? in_temperature : TEMP_DEFAULT;
    end
    if (cmd.op == OP_SEL_RUN && ram_re) begin
      ridx_r <= iss_r[SLOT_W-1:0];
    end
    case (cmd.op)
      OP_SEL_INIT: begin
        pre_lo_r <= '0;
        pre_hi_r <= '0;
        k_lo_r   <= K_LO;
        k_hi_r   <= K_HI;
        cnt_lo_r <= '0;
        cnt_hi_r <= '0;
        sat_r    <= 1'b0;
      end
      OP_SEL_RUN: begin
        if (rv_r) begin
          if (last_elem) begin
            cnt_lo_r <= '0;
            cnt_hi_r <= '0;
            if (k_lo_r >= cnt_lo_n) begin
              pre_lo_r[bit_r] <= 1'b1;
              k_lo_r <= k_lo_r - cnt_lo_n;
            end
            if (k_hi_r >= cnt_hi_n) begin
              pre_hi_r[bit_r] <= 1'b1;
              k_hi_r <= k_hi_r - cnt_hi_n;
            end
          end else begin
            cnt_lo_r <= cnt_lo_n;
            cnt_hi_r <= cnt_hi_n;
          end
        end
      end
      OP_VOLT_MUL: begin
        num_r <= {25'(med) * 25'(vref_r), 16'd0};
        den_r <= DEN_W'(22'(fs_eff) * 22'd1000);
      end
      OP_COMP_MUL: begin
        sat_r <= sat_r | v_over;
        num_r <= NUM_W'(28'(v_clamp) * 28'd800);
        den_r <= DEN_W'(den_t);
      end
      OP_SQUARE: begin
        cv_r  <= cv_clamp;
        sat_r <= sat_r | cv_over;
        v2_r  <= sq_full[38:16];
      end
      OP_CUBE: begin
        v3_r <= cube_full[41:16];
      end
      OP_TERMS: begin
        a_r <= 40'(v3_r) * 40'd13342;
        b_r <= 38'(v2_r) * 38'd25586;
        c_r <= 37'(cv_r) * 37'd85739;
      end
      OP_POLY: begin
        num_r <= (pos >= 41'(b_r)) ? NUM_W'(pos - 41'(b_r)) : '0;
      end
      OP_FINISH: begin
        if (poly_n >= PPM_SAT_LIM) begin
          res_ppm_r <= PPM_MAX;
          res_sat_r <= 1'b1;
        end else begin
          res_ppm_r <= poly_prod[41:26];
          res_sat_r <= sat_r;
        end
      end
      OP_OUT_LOAD: begin
        out_ppm_r <= res_ppm_r;
        out_sat_r <= res_sat_r;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_tds_ppm   = out_ppm_r;
  assign out_saturated = out_sat_r;
endmodule

@@ rtl/tds_median_compensated_meter.sv @@
// Median-filtered, temperature-compensated TDS meter. Each input transaction is one
// millisecond tick with the ADC code and water temperature. A tick that does not
// publish leaves the sequencer idle and ready. A publishing tick holds off the next
// transaction until its reading is loaded into the output register, which in turn
// waits for the previous reading to be taken: the median is found by a bit-serial radix
// select that sweeps the sample ring RAM once per ADC bit through its single read
// port, the voltage and compensation divisions share one bit-serial divider, and
// the final ppm scaling is a reciprocal multiply. The reading waits in an output
// register until taken.
`timescale 1ns / 1ps
module tds_median_compensated_meter #(
  parameter int SAMPLE_COUNT = tdsm_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tdsm_in_if.sink                              in_if,
  tdsm_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [tdsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tdsm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  tdsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdsm_datapath #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_adc_sample        (in_if.adc_sample),
    .in_temperature       (in_if.temperature),
    .in_temperature_valid (in_if.temperature_valid),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_ready            (out_if.ready),
    .out_valid            (out_if.valid),
    .out_tds_ppm          (out_if.tds_ppm),
    .out_saturated        (out_if.saturated)
  );

  assign in_if.ready = in_ready;
endmodule
